### rtl/itoad_pkg.sv
// Shared types, constants and the digit character table for the integer to
// ASCII digit converter. Depends on nothing.
package itoad_pkg;

  localparam int VALUE_W           = 32;
  localparam int MIN_W             = 5;
  localparam int CH_W              = 8;
  localparam int MAX_CHARS_DEFAULT = 16;
  localparam int QUEUE_DEPTH       = 2;
  localparam int BCD_DIGITS        = 10;
  localparam int NDIG_W            = 5;
  localparam int TOTAL_W           = 7;

  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_X     = 8'h78;
  localparam logic [CH_W-1:0] CH_NONE  = 8'h00;

  localparam logic [1:0] LEAD_NONE = 2'd0;
  localparam logic [1:0] LEAD_SIGN = 2'd1;
  localparam logic [1:0] LEAD_HEX  = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               negative;
    logic               hex;
    logic [MIN_W-1:0]   min_digits;
    logic               pad_err;
  } item_t;

  function automatic logic [CH_W-1:0] digit_char(input logic [3:0] d);
    logic [CH_W-1:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h61;
      4'd11:   c = 8'h62;
      4'd12:   c = 8'h63;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h65;
      4'd15:   c = 8'h66;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

### rtl/itoad_front.sv
// Front end: accepts input beats, takes the magnitude and flags oversized padding.
// Depends on itoad_pkg.
module itoad_front import itoad_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               is_signed,
  input  logic               hex,
  input  logic [MIN_W-1:0]   min_digits,
  input  logic               queue_full,
  output logic               push,
  output item_t              push_item
);

  logic negative;

  assign negative   = is_signed & value[VALUE_W-1];
  assign item_stall = queue_full;
  assign push       = item_valid & ~queue_full;

  always_comb begin
    push_item.mag        = negative ? (VALUE_W'(0) - value) : value;
    push_item.negative   = negative;
    push_item.hex        = hex;
    push_item.min_digits = min_digits;
    push_item.pad_err    = TOTAL_W'(min_digits) > TOTAL_W'(MAX_CHARS);
  end

endmodule

### rtl/itoad_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on itoad_pkg.
module itoad_queue import itoad_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = count == CW'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/itoad_back.sv
// Back end: decimal BCD conversion by shift and add-three, sizing, and
// character emission through an output register. Depends on itoad_pkg.
module itoad_back import itoad_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  item_t           head,
  input  logic            empty,
  output logic            pop,
  output logic            char_valid,
  input  logic            char_stall,
  output logic [CH_W-1:0] ch,
  output logic            last,
  output logic            error
);

  localparam int DW = $clog2(MAX_CHARS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIZE,
    S_EMIT
  } state_t;

  state_t             state;
  logic [VALUE_W-1:0] shift;
  logic [3:0]         bcd [BCD_DIGITS];
  logic [3:0]         bcd_next [BCD_DIGITS];
  logic [4:0]         bit_cnt;
  logic               negative;
  logic               hex_mode;
  logic [MIN_W-1:0]   min_dig;
  logic               err;
  logic [1:0]         pre;
  logic [DW-1:0]      didx;

  logic [NDIG_W-1:0]  nat;
  logic [NDIG_W-1:0]  nd;
  logic [1:0]         lead;
  logic [TOTAL_W-1:0] total;
  logic [DW-1:0]      di;
  logic [3:0]         dsel;
  logic               fire;
  logic [CH_W-1:0]    ch_next;
  logic               last_next;
  logic [4*BCD_DIGITS-1:0] hex_ext;

  assign pop     = (state == S_IDLE) && !empty;
  assign fire    = (state == S_EMIT) && (!char_valid || !char_stall);
  assign hex_ext = (4*BCD_DIGITS)'(head.mag);

  always_comb begin
    logic [3:0] adj [BCD_DIGITS];
    for (int k = 0; k < BCD_DIGITS; k++) begin
      adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
    bcd_next[0] = {adj[0][2:0], shift[VALUE_W-1]};
    for (int k = 1; k < BCD_DIGITS; k++) begin
      bcd_next[k] = {adj[k][2:0], adj[k-1][3]};
    end
  end

  always_comb begin
    nat = '0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd[k] != 4'd0) begin
        nat = NDIG_W'(k + 1);
      end
    end
    nd = (nat > NDIG_W'(min_dig)) ? nat : NDIG_W'(min_dig);
    if (nd == '0) begin
      nd = NDIG_W'(1);
    end
    lead  = negative ? LEAD_SIGN : (hex_mode ? LEAD_HEX : LEAD_NONE);
    total = TOTAL_W'(lead) + TOTAL_W'(nd);
  end

  always_comb begin
    di   = didx - 1'b1;
    dsel = (di < DW'(BCD_DIGITS)) ? bcd[di[3:0]] : 4'd0;
    if (err) begin
      ch_next   = CH_NONE;
      last_next = 1'b1;
    end else if (pre != LEAD_NONE) begin
      ch_next   = negative ? CH_MINUS : ((pre == LEAD_HEX) ? CH_ZERO : CH_X);
      last_next = 1'b0;
    end else begin
      ch_next   = digit_char(dsel);
      last_next = didx == DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
    end else begin
      if (fire) begin
        char_valid <= 1'b1;
        ch         <= ch_next;
        last       <= last_next;
        error      <= err;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            negative <= head.negative;
            hex_mode <= head.hex;
            min_dig  <= head.min_digits;
            err      <= head.pad_err;
            shift    <= head.mag;
            bit_cnt  <= '0;
            for (int k = 0; k < BCD_DIGITS; k++) begin
              bcd[k] <= head.hex ? hex_ext[4*k +: 4] : 4'd0;
            end
            if (head.pad_err) begin
              state <= S_EMIT;
            end else if (head.hex) begin
              state <= S_SIZE;
            end else begin
              state <= S_CONV;
            end
          end
        end
        S_CONV: begin
          bcd     <= bcd_next;
          shift   <= shift << 1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 5'd31) begin
            state <= S_SIZE;
          end
        end
        S_SIZE: begin
          err   <= total > TOTAL_W'(MAX_CHARS);
          pre   <= lead;
          didx  <= DW'(nd);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (fire) begin
            if (err || (pre == LEAD_NONE && didx == DW'(1))) begin
              state <= S_IDLE;
            end else if (pre != LEAD_NONE) begin
              pre <= pre - 1'b1;
            end else begin
              didx <= didx - 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/integer_to_ascii_digits_unit.sv
// Integer to ASCII digit converter: decimal or hex text, zero padded, signed.
// The shift and add-three loop takes one cycle per value bit; hex items skip it.
// The back end converts one item at a time, while the queue takes new beats until full.
// Reset (rst, synchronous) empties the queue and the output register.
// Depends on itoad_pkg, itoad_front, itoad_queue and itoad_back.
module integer_to_ascii_digits_unit import itoad_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               is_signed,
  input  logic               hex,
  input  logic [MIN_W-1:0]   min_digits,
  output logic               char_valid,
  input  logic               char_stall,
  output logic [CH_W-1:0]    ch,
  output logic               last,
  output logic               error
);

  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  full;
  logic  empty;

  itoad_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .is_signed  (is_signed),
    .hex        (hex),
    .min_digits (min_digits),
    .queue_full (full),
    .push       (push),
    .push_item  (push_item)
  );

  itoad_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  itoad_back #(.MAX_CHARS(MAX_CHARS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ch         (ch),
    .last       (last),
    .error      (error)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    char_valid && error |-> last && ch == CH_NONE)
    else $error("error beat is not a single zero character");

  a_reset_idle: assert property (@(posedge clk) rst |=> !char_valid && !empty == 1'b0)
    else $error("reset did not clear output and queue");

endmodule
